@@ design/binary_heap_priority_queue_macros.svh @@
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_macros
// Assertion macros for the heap queue RTL, used by bhpq_dp. Build with NO_ASSERTIONS
// defined to drop every check.
// ----------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every edge out of reset
`define BHPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a result in the next
`define BHPQ_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define BHPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define BHPQ_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

@@ design/bhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types and codes for the binary heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

    // input operation codes (carried on s_tuser)
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes (carried on m_tuser)
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // heap order
    localparam logic MODE_MIN = 1'b0;
    localparam logic MODE_MAX = 1'b1;

    // configuration register indexes
    localparam logic REG_HEAP_MODE = 1'b0;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_LAST,
        ST_DN_LEFT,
        ST_DN_RIGHT,
        ST_DN_CMP,
        ST_DONE
    } t_state;

    // datapath commands
    typedef enum logic [3:0] {
        DP_NOP,
        DP_START_INS,
        DP_START_REM,
        DP_UP_STEP,
        DP_UP_CMP,
        DP_DN_LOAD,
        DP_DN_LEFT,
        DP_DN_RIGHT,
        DP_DN_CMP,
        DP_EMIT
    } t_dp_op;

    // datapath status toward the controller
    typedef struct packed {
        logic full;        // count at capacity
        logic empty;       // no entries held
        logic last_one;    // exactly one entry held
        logic hole_root;   // hole sits at the root
        logic left_in;     // left child of hole is inside the heap
        logic up_moves;    // carried value beats the parent just read
        logic down_moves;  // a child beats the carried value
        logic out_busy;    // output register holds a beat not taken this cycle
    } t_dp_stat;

endpackage

@@ design/bhpq_ram.sv @@
// ----------------------------------------------------------------------------
// bhpq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 127
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bhpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bhpq_ctrl
// Sequencer for insert (sift up) and removal (sift down) on the heap store.
// ----------------------------------------------------------------------------
module bhpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_op,
    input  bhpq_pkg::t_dp_stat i_stat,
    output logic               o_ready,
    output bhpq_pkg::t_dp_op   o_dp_op
);
    import bhpq_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_dp_op = DP_NOP;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_op == OP_INSERT) begin
                        o_dp_op = DP_START_INS;
                        n_state = i_stat.full ? ST_DONE : ST_UP_RD;
                    end else begin
                        o_dp_op = DP_START_REM;
                        n_state = (i_stat.empty || i_stat.last_one) ? ST_DONE : ST_DN_LAST;
                    end
                end
            end
            ST_UP_RD: begin
                // at the root the value is written, else the parent is read
                o_dp_op = DP_UP_STEP;
                n_state = i_stat.hole_root ? ST_DONE : ST_UP_CMP;
            end
            ST_UP_CMP: begin
                o_dp_op = DP_UP_CMP;
                n_state = i_stat.up_moves ? ST_UP_RD : ST_DONE;
            end
            ST_DN_LAST: begin
                o_dp_op = DP_DN_LOAD;
                n_state = ST_DN_LEFT;
            end
            ST_DN_LEFT: begin
                o_dp_op = DP_DN_LEFT;
                n_state = i_stat.left_in ? ST_DN_RIGHT : ST_DONE;
            end
            ST_DN_RIGHT: begin
                o_dp_op = DP_DN_RIGHT;
                n_state = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                o_dp_op = DP_DN_CMP;
                n_state = i_stat.down_moves ? ST_DN_LEFT : ST_DONE;
            end
            ST_DONE: begin
                if (!i_stat.out_busy) begin
                    o_dp_op = DP_EMIT;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/bhpq_dp.sv @@
// ----------------------------------------------------------------------------
// bhpq_dp
// Heap datapath: store, hole pointer, carried value, compare and result beat.
// ----------------------------------------------------------------------------
`include "binary_heap_priority_queue_macros.svh"

module bhpq_dp #(
    parameter int CAPACITY = 127
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bhpq_pkg::t_dp_op              i_dp_op,
    input  logic                          i_mode,
    input  logic [bhpq_pkg::VALUE_W-1:0]  i_value,
    input  logic                          i_m_tready,
    output bhpq_pkg::t_dp_stat            o_stat,
    output logic                          o_m_tvalid,
    output logic [1:0]                    o_status,
    output logic [bhpq_pkg::VALUE_W-1:0]  o_removed,
    output logic [bhpq_pkg::VALUE_W-1:0]  o_top,
    output logic [bhpq_pkg::COUNT_W-1:0]  o_count
);
    import bhpq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    // strict order test under the current mode
    function automatic logic outranks(input logic mode, input logic [VALUE_W-1:0] a,
                                      input logic [VALUE_W-1:0] b);
        logic res;
        if (mode == MODE_MAX) begin
            res = $signed(a) > $signed(b);
        end else begin
            res = $signed(a) < $signed(b);
        end
        return res;
    endfunction

    logic [CW-1:0]      r_count;
    logic [VALUE_W-1:0] r_top;
    logic [VALUE_W-1:0] r_val;
    logic [VALUE_W-1:0] r_left;
    logic [AW-1:0]      r_hole;
    logic [1:0]         r_status;
    logic [VALUE_W-1:0] r_removed;
    logic               r_out_valid;
    logic [1:0]         r_o_status;
    logic [VALUE_W-1:0] r_o_removed;
    logic [VALUE_W-1:0] r_o_top;
    logic [COUNT_W-1:0] r_o_count;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic [AW-1:0]      parent;
    logic [IW-1:0]      left_x;
    logic [IW-1:0]      right_x;
    logic [IW-1:0]      count_x;
    logic               left_in;
    logic               right_in;
    logic               up_moves;
    logic               beats_l;
    logic               beats_r;
    logic [VALUE_W-1:0] best_l;
    logic               full;
    logic               empty;
    logic               last_one;
    logic               out_busy;

    bhpq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // tree index arithmetic
    assign parent   = AW'((r_hole - 1'b1) >> 1);
    assign left_x   = {1'b0, r_hole, 1'b1};
    assign right_x  = {1'b0, r_hole, 1'b0} + IW'(2);
    assign count_x  = IW'(r_count);
    assign left_in  = left_x < count_x;
    assign right_in = right_x < count_x;

    // compares; read data is the parent in UP_CMP and the right child in DN_CMP
    assign up_moves = outranks(i_mode, r_val, ram_rdata);
    assign beats_l  = outranks(i_mode, r_left, r_val);
    assign best_l   = beats_l ? r_left : r_val;
    assign beats_r  = right_in && outranks(i_mode, ram_rdata, best_l);

    assign full     = r_count == CW'(CAPACITY);
    assign empty    = r_count == '0;
    assign last_one = r_count == CW'(1);
    assign out_busy = r_out_valid && !i_m_tready;

    always_comb begin
        o_stat.full       = full;
        o_stat.empty      = empty;
        o_stat.last_one   = last_one;
        o_stat.hole_root  = r_hole == '0;
        o_stat.left_in    = left_in;
        o_stat.up_moves   = up_moves;
        o_stat.down_moves = beats_l || beats_r;
        o_stat.out_busy   = out_busy;
    end

    // store port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_hole;
        ram_wdata = r_val;
        ram_raddr = r_hole;
        unique case (i_dp_op)
            DP_START_REM: begin
                ram_raddr = AW'(r_count - 1'b1);
            end
            DP_UP_STEP: begin
                if (r_hole == '0) begin
                    ram_we = 1'b1;
                end else begin
                    ram_raddr = parent;
                end
            end
            DP_UP_CMP: begin
                ram_we    = 1'b1;
                ram_wdata = up_moves ? ram_rdata : r_val;
            end
            DP_DN_LEFT: begin
                if (!left_in) begin
                    ram_we = 1'b1;
                end else begin
                    ram_raddr = left_x[AW-1:0];
                end
            end
            DP_DN_RIGHT: begin
                ram_raddr = right_x[AW-1:0];
            end
            DP_DN_CMP: begin
                ram_we    = 1'b1;
                ram_wdata = beats_r ? ram_rdata : best_l;
            end
            default: begin
            end
        endcase
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_dp_op == DP_START_INS && !full) begin
            r_count <= r_count + 1'b1;
        end else if (i_dp_op == DP_START_REM && !empty) begin
            r_count <= r_count - 1'b1;
        end
    end

    // shadow of the root; zero while empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
        end else if (i_dp_op == DP_START_REM && last_one) begin
            r_top <= '0;
        end else if (ram_we && ram_waddr == '0) begin
            r_top <= ram_wdata;
        end
    end

    // sift working registers and pending result
    always_ff @(posedge i_clk) begin
        unique case (i_dp_op)
            DP_START_INS: begin
                r_removed <= '0;
                r_status  <= full ? STAT_FULL : STAT_DONE;
                r_val     <= i_value;
                r_hole    <= AW'(r_count);
            end
            DP_START_REM: begin
                r_removed <= empty ? '0 : r_top;
                r_status  <= empty ? STAT_EMPTY : STAT_DONE;
            end
            DP_UP_CMP: begin
                if (up_moves) begin
                    r_hole <= parent;
                end
            end
            DP_DN_LOAD: begin
                r_val  <= ram_rdata;
                r_hole <= '0;
            end
            DP_DN_RIGHT: begin
                r_left <= ram_rdata;
            end
            DP_DN_CMP: begin
                if (beats_r) begin
                    r_hole <= right_x[AW-1:0];
                end else if (beats_l) begin
                    r_hole <= left_x[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_op == DP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_dp_op == DP_EMIT) begin
            r_o_status  <= r_status;
            r_o_removed <= r_removed;
            r_o_top     <= r_top;
            r_o_count   <= COUNT_W'(r_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_status   = r_o_status;
    assign o_removed  = r_o_removed;
    assign o_top      = r_o_top;
    assign o_count    = r_o_count;

    `BHPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY), "count past capacity")
    `BHPQ_ASSERT(a_empty_top, i_clk, i_rst_n, (r_count != '0) || (r_top == '0), "top set while empty")
    `BHPQ_ASSERT(a_emit_free, i_clk, i_rst_n, (i_dp_op != DP_EMIT) || !out_busy, "emit over beat")
    `BHPQ_ASSERT_NEXT(a_ins_count, i_clk, i_rst_n, (i_dp_op == DP_START_INS) && !full, r_count == CW'($past(r_count) + 1'b1), "insert count step")

endmodule

@@ design/binary_heap_priority_queue.sv @@
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Binary heap priority queue with stream ports and an APB mode register.
// ----------------------------------------------------------------------------
// Each input beat inserts a signed value (s_tuser = 0) or removes the root
// (s_tuser = 1) and yields one result beat with the status, the removed value,
// the new top and the entry count. heap_mode at byte address 0 picks a min
// heap (0) or max heap (1); write it only while no beat is in flight. One
// beat is worked on at a time, paced by the store with its registered read:
// an insert climbs from the new last slot, reading each parent and moving it
// down while the value outranks it; a removal moves the last entry to the root
// and sinks it, reading the left and then the right child at each level
// (rejected operations and the removal of the last entry skip the sift). A new
// beat is taken only once the result of the last one sits in the output
// register, and a result beat waits there for m_tready.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue #(
    parameter int CAPACITY = 127
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tuser,   // [0] operation
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] removed_value, [63:32] top_value,
                                   // [70:64] entry_count, [71] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bhpq_pkg::*;

    logic     r_mode;
    t_dp_op   dp_op;
    t_dp_stat dp_stat;

    logic [1:0]         res_status;
    logic [VALUE_W-1:0] res_removed;
    logic [VALUE_W-1:0] res_top;
    logic [COUNT_W-1:0] res_count;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_MAX;
        end else if (psel && penable && pwrite && paddr[2] == REG_HEAP_MODE) begin
            r_mode <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEAP_MODE) ? {31'b0, r_mode} : 32'b0;

    bhpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_op    (s_tuser),
        .i_stat  (dp_stat),
        .o_ready (s_tready),
        .o_dp_op (dp_op)
    );

    bhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dp_op    (dp_op),
        .i_mode     (r_mode),
        .i_value    (s_tdata),
        .i_m_tready (m_tready),
        .o_stat     (dp_stat),
        .o_m_tvalid (m_tvalid),
        .o_status   (res_status),
        .o_removed  (res_removed),
        .o_top      (res_top),
        .o_count    (res_count)
    );

    // pack the result beat
    assign m_tuser = res_status;
    assign m_tdata = {1'b0, res_count, res_top, res_removed};

endmodule

@@ tb/tb_binary_heap_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_heap_priority_queue
// Self-checking bench for the binary heap priority queue.
// ----------------------------------------------------------------------------
// A short directed run covers the value extremes, equal values, removal from an
// empty heap and a change of heap order while entries are held. Random phases
// then switch between min and max order with insert-heavy, remove-heavy and
// balanced mixes, so the heap reaches full and empty many times. A heap model
// inside the scoreboard predicts every result beat. The sender runs in random
// bursts and the receiver stalls on its own pattern, including one long
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_binary_heap_priority_queue;
    import bhpq_pkg::*;

    localparam int HEAP_DEPTH = 127;
    localparam logic [2:0] MODE_ADDR = 3'(4 * REG_HEAP_MODE);
    localparam int SETTLE_CYCLES = 30;
    localparam int LONG_HOLD_CYCLES = 400;

    // one predicted result beat
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed;
        logic signed [31:0] top;
        logic [6:0]         count;
    } t_heap_result;

    // heap model and queue of awaited result beats
    class t_heap_scoreboard;
        logic signed [31:0] slots [HEAP_DEPTH];
        int                 held;
        logic               order;
        t_heap_result       awaited [$];
        int                 errors;

        function new();
            held   = 0;
            order  = MODE_MAX;
            errors = 0;
        endfunction

        function void set_order(logic m);
            order = m;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // strict comparison under the current order
        function bit ranks_above(logic signed [31:0] a, logic signed [31:0] b);
            if (order == MODE_MAX)
                return a > b;
            return a < b;
        endfunction

        function void swap_slots(int i, int j);
            logic signed [31:0] t;
            t        = slots[i];
            slots[i] = slots[j];
            slots[j] = t;
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        // apply one accepted input beat to the model
        function void note_input(logic op, logic signed [31:0] val);
            t_heap_result r;
            int           i;
            int           parent;
            int           pick;
            bit           moving;
            r.status  = STAT_DONE;
            r.removed = '0;
            if (op == OP_INSERT) begin
                if (held >= HEAP_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    slots[held] = val;
                    i = held;
                    held++;
                    moving = 1'b1;
                    while (moving && i > 0) begin
                        parent = (i - 1) / 2;
                        if (ranks_above(slots[i], slots[parent])) begin
                            swap_slots(i, parent);
                            i = parent;
                        end else begin
                            moving = 1'b0;
                        end
                    end
                end
            end else if (held == 0) begin
                r.status = STAT_EMPTY;
            end else begin
                r.removed = slots[0];
                held--;
                slots[0] = slots[held];
                i = 0;
                moving = 1'b1;
                while (moving) begin
                    // left child wins a tie with the right
                    pick = i;
                    if (2 * i + 1 < held && ranks_above(slots[2 * i + 1], slots[pick]))
                        pick = 2 * i + 1;
                    if (2 * i + 2 < held && ranks_above(slots[2 * i + 2], slots[pick]))
                        pick = 2 * i + 2;
                    if (pick == i) begin
                        moving = 1'b0;
                    end else begin
                        swap_slots(i, pick);
                        i = pick;
                    end
                end
            end
            r.top   = (held > 0) ? slots[0] : '0;
            r.count = 7'(held);
            awaited.push_back(r);
        endfunction

        // compare one accepted result beat with the oldest prediction
        function void check_result(t_heap_result got);
            t_heap_result exp;
            if (awaited.size() == 0) begin
                flag($sformatf("result beat with nothing awaited: status %0d", got.status));
                return;
            end
            exp = awaited.pop_front();
            if (got.status !== exp.status)
                flag($sformatf("status exp %0d got %0d", exp.status, got.status));
            if (got.removed !== exp.removed)
                flag($sformatf("removed exp %0d got %0d", exp.removed, got.removed));
            if (got.top !== exp.top)
                flag($sformatf("top exp %0d got %0d", exp.top, got.top));
            if (got.count !== exp.count)
                flag($sformatf("count exp %0d got %0d", exp.count, got.count));
        endfunction

        function void check_readback(logic [31:0] got);
            if (got !== {31'b0, order})
                flag($sformatf("heap_mode readback exp %0d got %h", order, got));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value
    logic        s_tuser;   // [0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // [31:0] removed, [63:32] top, [70:64] count
    logic [1:0]  m_tuser;   // [1:0] status
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_heap_scoreboard sb;
    int               burst_left;
    bit               hold_req;

    binary_heap_priority_queue #(
        .CAPACITY(HEAP_DEPTH)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_result({m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[70:64]});
    end

    // receiver: stall pattern plus one long hold-off on request
    initial begin : receiver
        int pat_kind;
        int pat_left;
        pat_kind = 0;
        pat_left = 0;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (pat_left == 0) begin
                    pat_kind = $urandom_range(0, 2);
                    pat_left = $urandom_range(10, 80);
                end
                pat_left--;
                case (pat_kind)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // APB access: setup then access phase; returns prdata of the access cycle
    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write the heap order, then read it back
    task automatic write_heap_mode(input logic m);
        logic [31:0] rd;
        apb_access(1'b1, MODE_ADDR, {31'($urandom), m}, rd);
        sb.set_order(m);
        apb_access(1'b0, MODE_ADDR, 32'h0, rd);
        sb.check_readback(rd);
    endtask

    // offer one beat; bursts of random length with random gaps in between
    task automatic send_item(input logic op, input logic [31:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_input(op, val);
        burst_left--;
        @(negedge i_clk);
    endtask

    // stop offering and let every awaited beat drain
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // mix of wide random values, a narrow band for ties, and extremes
    function automatic logic [31:0] pick_value();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5)
            return $urandom;
        if (k < 8)
            return 32'($signed($urandom_range(0, 15)) - 8);
        case ($urandom_range(0, 3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // one random phase under a given order and insert share
    task automatic run_phase(input logic m, input int insert_pct, input int n, input bit hold);
        logic op;
        wait_drained();
        write_heap_mode(m);
        if (hold)
            hold_req = 1'b1;
        repeat (n) begin
            op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
            send_item(op, pick_value());
        end
    endtask

    // stimulus
    initial begin
        sb         = new();
        burst_left = 0;
        hold_req   = 1'b0;
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_INSERT;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty removal, extremes, ties, under the reset order
        send_item(OP_REMOVE, 32'h1234_5678);
        send_item(OP_INSERT, 32'h7fff_ffff);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'hffff_ffff);
        send_item(OP_INSERT, 32'h7fff_ffff);
        send_item(OP_INSERT, 32'h0000_0001);
        send_item(OP_INSERT, 32'h0000_0005);
        send_item(OP_INSERT, 32'h0000_0005);
        send_item(OP_INSERT, 32'h0000_0005);
        repeat (3) send_item(OP_REMOVE, 32'hffff_ffff);

        // order flipped with entries held; entries are not reordered
        wait_drained();
        write_heap_mode(MODE_MIN);
        send_item(OP_INSERT, 32'hffff_fffe);
        repeat (9) send_item(OP_REMOVE, 32'h0);

        // random phases; the first one also holds the receiver off
        run_phase(MODE_MAX, 90, 180, 1'b1);
        run_phase(MODE_MAX, 10, 180, 1'b0);
        run_phase(MODE_MIN, 90, 180, 1'b0);
        run_phase(MODE_MAX, 50, 150, 1'b0);
        run_phase(MODE_MIN, 10, 180, 1'b0);
        run_phase(MODE_MIN, 95, 180, 1'b0);
        run_phase(MODE_MAX, 50, 150, 1'b0);
        run_phase(MODE_MIN, 20, 200, 1'b0);

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/bhpq_pkg.sv
design/bhpq_ram.sv
design/bhpq_ctrl.sv
design/bhpq_dp.sv
design/binary_heap_priority_queue.sv
tb/tb_binary_heap_priority_queue.sv
